FILE: hw/rtl/vru_pkg.sv
// Shared register map and constants for the vertex Euler rotation unit.
`default_nettype none

package vru_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vru_cell.sv
// One rotation cell: two-stage plane rotation of a coordinate pair, third coordinate rides along.
`default_nettype none

module vru_cell #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] in_p,
  input  logic signed [COORD_WIDTH-1:0] in_q,
  input  logic signed [COORD_WIDTH-1:0] in_r,
  input  logic signed [TRIG_WIDTH:0]    c_pp,
  input  logic signed [TRIG_WIDTH:0]    c_qp,
  input  logic signed [TRIG_WIDTH:0]    c_pq,
  input  logic signed [TRIG_WIDTH:0]    c_qq,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_p,
  output logic signed [COORD_WIDTH-1:0] out_q,
  output logic signed [COORD_WIDTH-1:0] out_r
);

  localparam int CFW  = TRIG_WIDTH + 1;
  localparam int PW   = COORD_WIDTH + CFW;
  localparam int FRAC = TRIG_WIDTH - 2;
  localparam int SW   = PW - FRAC;
  localparam int SUMW = SW + 1;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  logic                          v1;
  logic signed [PW-1:0]          m_pp, m_qp, m_pq, m_qq;
  logic signed [COORD_WIDTH-1:0] r1;

  logic signed [SW-1:0]   sh_pp, sh_qp, sh_pq, sh_qq;
  logic signed [SUMW-1:0] sum_p, sum_q;
  logic signed [COORD_WIDTH-1:0] sat_p, sat_q;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pp <= PW'(in_p) * PW'(c_pp);
      m_qp <= PW'(in_q) * PW'(c_qp);
      m_pq <= PW'(in_p) * PW'(c_pq);
      m_qq <= PW'(in_q) * PW'(c_qq);
      r1   <= in_r;
    end
  end

  // stage 2: floor each product, add, clamp
  always_comb begin
    sh_pp = SW'(m_pp >>> FRAC);
    sh_qp = SW'(m_qp >>> FRAC);
    sh_pq = SW'(m_pq >>> FRAC);
    sh_qq = SW'(m_qq >>> FRAC);
    sum_p = SUMW'(sh_pp) + SUMW'(sh_qp);
    sum_q = SUMW'(sh_pq) + SUMW'(sh_qq);
    if (sum_p > SAT_HI) begin
      sat_p = COORD_WIDTH'(SAT_HI);
    end else if (sum_p < SAT_LO) begin
      sat_p = COORD_WIDTH'(SAT_LO);
    end else begin
      sat_p = COORD_WIDTH'(sum_p);
    end
    if (sum_q > SAT_HI) begin
      sat_q = COORD_WIDTH'(SAT_HI);
    end else if (sum_q < SAT_LO) begin
      sat_q = COORD_WIDTH'(SAT_LO);
    end else begin
      sat_q = COORD_WIDTH'(sum_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p <= sat_p;
      out_q <= sat_q;
      out_r <= r1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_euler_rotation_unit.sv
// Usage notes:
// Rotates one vertex per word about X, then Y, then Z, using Q2.14 cosine and
// sine values held in six registers (cos/sin for X, Y, Z at indexes 0..5).
// Input stream: s_axis_tdata = {z, y, x}, signed Q16.16, x in the low bits.
// Output stream: m_axis_tdata = {z, y, x}, rotated and saturated per axis.
// Config port: cfg_wr_en, cfg_index, cfg_data; the user must write it only while
// idle, as the block does not enforce this. Indexes 6 and 7 are ignored.
// Throughput: one word per cycle unless the pipe holds. There are six register
// stages, two per axis cell (multiply register, then floor/add/clamp register);
// the last cell's register is the output register.
// The whole row of cells advances together; it holds while m_axis_tvalid is
// high and m_axis_tready is low, and s_axis_tready drops with it.
// Reset (rst, synchronous) empties the pipe and loads cos = 1.0, sin = 0 on
// every axis, which passes vertices through unchanged.
`default_nettype none

module vertex_euler_rotation_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // fields from bit 0: in_x, in_y, in_z, zero pad
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // fields from bit 0: out_x, out_y, out_z, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  input  logic                                       cfg_wr_en,
  input  logic [vru_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [TRIG_WIDTH-1:0]                      cfg_data
);

  import vru_pkg::*;

  localparam int DATA_W = ((3*COORD_WIDTH+7)/8)*8;
  localparam int CFW    = TRIG_WIDTH + 1;
  localparam logic [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1) << (TRIG_WIDTH - 2);

  logic signed [TRIG_WIDTH-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x <= TRIG_ONE;
      sin_x <= '0;
      cos_y <= TRIG_ONE;
      sin_y <= '0;
      cos_z <= TRIG_ONE;
      sin_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS_X: cos_x <= cfg_data;
        REG_SIN_X: sin_x <= cfg_data;
        REG_COS_Y: cos_y <= cfg_data;
        REG_SIN_Y: sin_y <= cfg_data;
        REG_COS_Z: cos_z <= cfg_data;
        REG_SIN_Z: sin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // one extra bit so that negating the most negative sine stays exact
  logic signed [CFW-1:0] cx, sx, nsx, cy, sy, nsy, cz, sz, nsz;

  always_comb begin
    cx  = CFW'(cos_x);
    sx  = CFW'(sin_x);
    nsx = -sx;
    cy  = CFW'(cos_y);
    sy  = CFW'(sin_y);
    nsy = -sy;
    cz  = CFW'(cos_z);
    sz  = CFW'(sin_z);
    nsz = -sz;
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [COORD_WIDTH-1:0] x0, y0, z0;
  assign x0 = s_axis_tdata[COORD_WIDTH-1:0];
  assign y0 = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign z0 = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  logic                          v1, v2, v3;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;

  // X: y' = y*cx - z*sx, z' = y*sx + z*cx
  vru_cell #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_cell_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .in_p(y0), .in_q(z0), .in_r(x0),
    .c_pp(cx), .c_qp(nsx), .c_pq(sx), .c_qq(cx),
    .out_valid(v1), .out_p(y1), .out_q(z1), .out_r(x1)
  );

  // Y: x' = x*cy + z*sy, z' = -x*sy + z*cy
  vru_cell #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_cell_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .in_p(x1), .in_q(z1), .in_r(y1),
    .c_pp(cy), .c_qp(sy), .c_pq(nsy), .c_qq(cy),
    .out_valid(v2), .out_p(x2), .out_q(z2), .out_r(y2)
  );

  // Z: x' = x*cz - y*sz, y' = x*sz + y*cz
  vru_cell #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_cell_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .in_p(x2), .in_q(y2), .in_r(z2),
    .c_pp(cz), .c_qp(nsz), .c_pq(sz), .c_qq(cz),
    .out_valid(v3), .out_p(x3), .out_q(y3), .out_r(z3)
  );

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = DATA_W'({z3, y3, x3});

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for vertex_euler_rotation_unit against an XYZ rotation predictor.
`timescale 1ns / 1ps

module tb_top;
  import vru_pkg::*;

  localparam int COORD_W      = 32;
  localparam int TRIG_W       = 16;
  localparam int TRIG_FRAC    = TRIG_W - 2;
  localparam int DATA_W       = ((3 * COORD_W + 7) / 8) * 8;
  localparam int PIPE_LATENCY = 6;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_WORDS  = 78;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  localparam logic signed [COORD_W-1:0] C_HI  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_LO  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;

  localparam logic signed [TRIG_W-1:0] T_ONE  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] T_MONE = -16'sd16384;
  localparam logic signed [TRIG_W-1:0] T_MOST = 16'sh8000;
  localparam logic signed [TRIG_W-1:0] T_DIAG = 16'sd11585;

  // spare decode slots past the last trig register
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam cfg_reg_t TRIG_REGS [6] = '{REG_COS_X, REG_SIN_X, REG_COS_Y,
                                         REG_SIN_Y, REG_COS_Z, REG_SIN_Z};

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  localparam vertex_t CORNERS [8] = '{
    '{32'sd0, 32'sd0, 32'sd0},
    '{C_HI, C_HI, C_HI},
    '{C_LO, C_LO, C_LO},
    '{32'sd0, C_LO, C_HI},
    '{C_ONE, -32'sd1, 32'sd1},
    '{-C_ONE, 32'sd1, -32'sd1},
    '{32'sh0F0F_0F0F, 32'shAAAA_AAAA, 32'sh5555_5555},
    '{C_LO, C_HI, -C_ONE}
  };

  class rotation_scoreboard;
    logic signed [TRIG_W-1:0] trig [8];
    vertex_t rotated_q [$];
    int failures;

    function new();
      trig[REG_COS_X] = T_ONE;  trig[REG_SIN_X] = '0;
      trig[REG_COS_Y] = T_ONE;  trig[REG_SIN_Y] = '0;
      trig[REG_COS_Z] = T_ONE;  trig[REG_SIN_Z] = '0;
      failures = 0;
    endfunction

    function void write_trig(logic [CFG_IDX_W-1:0] idx, logic [TRIG_W-1:0] val);
      if (idx <= REG_SIN_Z) begin
        trig[idx] = val;
      end
    endfunction

    // two products, each floored on its own, then clamp to the coordinate range
    function longint mix(longint a, longint ca, longint b, longint cb);
      longint s;
      s = ((a * ca) >>> TRIG_FRAC) + ((b * cb) >>> TRIG_FRAC);
      if (s > COORD_MAX) s = COORD_MAX;
      else if (s < COORD_MIN) s = COORD_MIN;
      return s;
    endfunction

    function vertex_t rotate_xyz(vertex_t v);
      longint x, y, z, t;
      longint cx, sx, cy, sy, cz, sz;
      vertex_t r;
      x = longint'(v.x);  y = longint'(v.y);  z = longint'(v.z);
      cx = longint'(trig[REG_COS_X]);  sx = longint'(trig[REG_SIN_X]);
      cy = longint'(trig[REG_COS_Y]);  sy = longint'(trig[REG_SIN_Y]);
      cz = longint'(trig[REG_COS_Z]);  sz = longint'(trig[REG_SIN_Z]);
      t = mix(y, cx, z, -sx);  z = mix(y, sx, z, cx);   y = t;
      t = mix(x, cy, z, sy);   z = mix(x, -sy, z, cy);  x = t;
      t = mix(x, cz, y, -sz);  y = mix(x, sz, y, cz);   x = t;
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.z = z[COORD_W-1:0];
      return r;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void note_input(vertex_t v);
      rotated_q.push_back(rotate_xyz(v));
    endfunction

    function void compare_field(string name, logic signed [COORD_W-1:0] got,
                                logic signed [COORD_W-1:0] want);
      if (got !== want) note_failure($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_output(vertex_t got);
      vertex_t want;
      if (rotated_q.size() == 0) begin
        note_failure($sformatf("word with nothing expected: x=%0d y=%0d z=%0d",
                               got.x, got.y, got.z));
        return;
      end
      want = rotated_q.pop_front();
      compare_field("out_x", got.x, want.x);
      compare_field("out_y", got.y, want.y);
      compare_field("out_z", got.z, want.z);
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TRIG_W-1:0]    cfg_data;

  rotation_scoreboard sb = new();

  int send_gap_pct;
  int ready_gap_pct;
  bit hold_request;

  vertex_euler_rotation_unit #(
    .COORD_WIDTH(COORD_W),
    .TRIG_WIDTH (TRIG_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** vertex_euler_rotation_unit: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) sb.write_trig(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata[3*COORD_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata[3*COORD_W-1:0]);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (ready_gap_pct > 0 && $urandom_range(0, 99) < ready_gap_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? C_HI : C_LO;
      1, 2, 3: return $urandom;
      default: return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    return v;
  endfunction

  task automatic send_vertex(vertex_t v);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic load_trig(logic signed [TRIG_W-1:0] vals [6]);
    foreach (TRIG_REGS[i]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= TRIG_REGS[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // the spare slots must not disturb any trig register
    cfg_index <= IDX_SPARE_LO;
    cfg_data  <= TRIG_W'($urandom);
    @(posedge clk);
    cfg_index <= IDX_SPARE_HI;
    cfg_data  <= TRIG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    logic signed [TRIG_W-1:0] angles [6];
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    send_gap_pct  = 20;
    ready_gap_pct = 20;
    hold_request  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset
    foreach (CORNERS[i]) send_vertex(CORNERS[i]);
    drain();

    // most negative pattern everywhere: every cos and sin is -2.0, driving saturation
    foreach (angles[i]) angles[i] = T_MOST;
    load_trig(angles);
    foreach (CORNERS[i]) send_vertex(CORNERS[i]);
    drain();

    // cos at +1, sin at -1 on every axis
    foreach (angles[i]) angles[i] = (i % 2 == 0) ? T_ONE : T_MONE;
    load_trig(angles);
    foreach (CORNERS[i]) send_vertex(CORNERS[i]);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          foreach (angles[i]) angles[i] = (i % 2 == 0) ? 16'sd0 : T_ONE;
          send_gap_pct = 20;  ready_gap_pct = 20;
        end
        1: begin
          foreach (angles[i]) angles[i] = (i % 2 == 0) ? T_MONE : 16'sd0;
          send_gap_pct = 0;   ready_gap_pct = 0;
        end
        2: begin
          angles = '{T_DIAG, T_DIAG, T_DIAG, -T_DIAG, -T_DIAG, T_DIAG};
          send_gap_pct = 0;   ready_gap_pct = 30;
        end
        3: begin
          foreach (angles[i]) angles[i] = (i % 2 == 0) ? 16'sd0 : T_MONE;
          send_gap_pct = 40;  ready_gap_pct = 10;
        end
        5: begin
          foreach (angles[i]) angles[i] = TRIG_W'($urandom);
          send_gap_pct = 25;  ready_gap_pct = 25;
        end
        default: begin
          foreach (angles[i]) angles[i] = TRIG_W'(int'($urandom_range(0, 32768)) - 16384);
          send_gap_pct  = (phase == 7) ? 0 : 10 + 10 * (phase % 3);
          ready_gap_pct = (phase == 7) ? 0 : 40 - 10 * (phase % 3);
        end
      endcase
      load_trig(angles);
      // long output stall while the sender keeps offering words
      if (phase == 2) hold_request = 1'b1;
      repeat (PHASE_WORDS) send_vertex(random_vertex());
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** vertex_euler_rotation_unit: PASSED **");
    end else begin
      $display("** vertex_euler_rotation_unit: FAILED **");
    end
    $finish;
  end

endmodule
